// ===== hdl/opl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opl_pkg: shared types and constants of the octree preorder label unit
// Request and result payloads, field widths and register reset value.
// ----------------------------------------------------------------------------
package opl_pkg;

  localparam int unsigned DEPTH_W       = 5;
  localparam int unsigned COORD_W       = 20;
  localparam int unsigned LABEL_W       = 61;
  localparam int unsigned MAX_LEVELS_DF = 20;

  localparam logic [DEPTH_W-1:0] TREE_DEPTH_RST = DEPTH_W'(10);

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } opl_req_t;

  typedef struct packed {
    logic [LABEL_W-1:0] preorder_label;
    logic               depth_error;
  } opl_res_t;

endpackage

`default_nettype wire

// ===== hdl/opl_label_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opl_label_calc: preorder label of one octree cell
// Suffix sums of the masked Morton digits give the octal column sums of the
// label; three shifted rows of those sums and the depth add up to the label.
// ----------------------------------------------------------------------------
module opl_label_calc #(
  parameter int unsigned MAX_LEVELS = opl_pkg::MAX_LEVELS_DF
) (
  input  opl_pkg::opl_req_t              req_i,
  input  logic [opl_pkg::DEPTH_W-1:0]    tree_depth_i,
  output opl_pkg::opl_res_t              res_o
);
  import opl_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_LEVELS + 1);
  localparam int unsigned CW  = $clog2(7 * MAX_LEVELS + 1);
  localparam int unsigned NR  = (CW + 2) / 3;
  localparam int unsigned LOW = DEPTH_W + 1;

  logic [DEPTH_W-1:0] md;
  logic               err;
  logic [CW-1:0]      scan [IW+1][MAX_LEVELS+1];
  logic [CW-1:0]      csum [MAX_LEVELS];
  logic [LABEL_W-1:0] row  [NR];
  logic [LABEL_W-1:0] total;

  // saturate the tree depth
  assign md  = (tree_depth_i > DEPTH_W'(MAX_LEVELS)) ? DEPTH_W'(MAX_LEVELS) : tree_depth_i;
  assign err = (req_i.depth > md);

  // masked digits, level order
  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_dig
    assign scan[0][l] = (DEPTH_W'(l) < req_i.depth) ?
                        CW'({req_i.coord_z[l], req_i.coord_y[l], req_i.coord_x[l]}) : '0;
  end
  assign scan[0][MAX_LEVELS] = '0;

  // suffix sums, log-step scan
  for (genvar k = 0; k < IW; k++) begin : g_scan
    for (genvar j = 0; j <= MAX_LEVELS; j++) begin : g_col
      if (j + (1 << k) <= MAX_LEVELS) begin : g_add
        assign scan[k+1][j] = scan[k][j] + scan[k][j + (1 << k)];
      end else begin : g_keep
        assign scan[k+1][j] = scan[k][j];
      end
    end
  end

  // digit sum for each octal column of the label
  for (genvar p = 0; p < MAX_LEVELS; p++) begin : g_col_sum
    logic [LOW-1:0] top;
    logic [LOW-1:0] lo;
    assign top = LOW'(req_i.depth) + LOW'(p);
    assign lo  = top - LOW'(md);
    always_comb begin
      if (top < LOW'(md)) begin
        csum[p] = scan[IW][0];
      end else if (lo > LOW'(MAX_LEVELS)) begin
        csum[p] = '0;
      end else begin
        csum[p] = scan[IW][lo[IW-1:0]];
      end
    end
  end

  // column sums spread over rows of 3-bit slices
  for (genvar r = 0; r < NR; r++) begin : g_row
    for (genvar pos = 0; pos < LABEL_W; pos++) begin : g_bit
      if ((pos / 3 >= r) && (pos / 3 - r < MAX_LEVELS) && (3 * r + pos % 3 < CW)) begin : g_src
        assign row[r][pos] = csum[pos / 3 - r][3 * r + pos % 3];
      end else begin : g_zero
        assign row[r][pos] = 1'b0;
      end
    end
  end

  always_comb begin
    total = LABEL_W'(req_i.depth);
    for (int r = 0; r < NR; r++) begin
      total = total + row[r];
    end
  end

  assign res_o.preorder_label = err ? '0 : total;
  assign res_o.depth_error    = err;

endmodule

`default_nettype wire

// ===== hdl/octree_preorder_label_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octree_preorder_label_unit: preorder visit number of an octree cell
// Request: depth and x, y, z cell indices. Result: the cell's position in a
// preorder walk of a complete octree of configured depth, or an error flag.
// ----------------------------------------------------------------------------
// Usage
//   in channel : in_valid_i / in_stall_o / in_req_i, one request per cell
//   out channel: out_valid_o / out_stall_i / out_res_o, one result per request
//   config     : cfg_we_i writes cfg_wdata_i into the tree depth; write it
//                only while no request is in flight. Values above MAX_LEVELS
//                saturate to MAX_LEVELS.
//   From request accept to result valid a request passes an input register,
//   then the label logic into the result register. A request can be
//   accepted every cycle while in_stall_o is low; the label logic is a digit
//   scan and a four-operand add feeding the result register.
//   A stalled result holds in the result register while the input register
//   still takes one more request; in_stall_o rises only when both are full.
//   Reset empties both registers and sets the tree depth to 10.
// ----------------------------------------------------------------------------
module octree_preorder_label_unit #(
  parameter int unsigned MAX_LEVELS = opl_pkg::MAX_LEVELS_DF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [opl_pkg::DEPTH_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  opl_pkg::opl_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output opl_pkg::opl_res_t             out_res_o
);
  import opl_pkg::*;

  logic [DEPTH_W-1:0] tree_depth_q;
  logic               s1_valid_q;
  opl_req_t           s1_req_q;
  logic               out_valid_q;
  opl_res_t           out_res_q;
  opl_res_t           res_d;
  logic               out_free;
  logic               s1_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_depth_q <= TREE_DEPTH_RST;
    end else if (cfg_we_i) begin
      tree_depth_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_req_q <= in_req_i;
    end
    if (out_free && s1_valid_q) begin
      out_res_q <= res_d;
    end
  end

  opl_label_calc #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_calc (
    .req_i        (s1_req_q),
    .tree_depth_i (tree_depth_q),
    .res_o        (res_d)
  );

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // error results carry a zero label
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.depth_error |-> out_res_q.preorder_label == '0)
    else $error("depth error with nonzero label");

  // input stalls only when the result is blocked and the input register is full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && s1_valid_q)
    else $error("input stalled without a blocked result");

  // an accepted request lands in the input register
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted request lost");

  // a held request moves to the result register when it is free
  a_s1_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_free |=> out_valid_q)
    else $error("request not moved to result register");

  // a blocked result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("blocked result dropped");

endmodule

`default_nettype wire
